[src/csd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: shared definitions
// Field widths, parameter defaults, command codes and helper functions used
// across the front end, the queue, the sort engine and the top level.
// ----------------------------------------------------------------------------
package csd_pkg;

  // Fixed widths of the transaction fields.
  localparam int TAG_W = 16;
  localparam int KEY_W = 8;

  // Number of distinct key values that an 8-bit key can take.
  localparam int KEY_RANGE = 1 << KEY_W;

  // Parameter defaults.
  localparam int MAX_ITEMS_DEF   = 64;
  localparam int KEY_BUCKETS_DEF = 256;
  localparam int TAG_BITS_DEF    = 16;

  // Depth of the queue between front end and sort engine (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // Command codes carried in the cmd field.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SORT = 1'b1
  } cmd_t;

  // Buckets that can actually be reached: keys never exceed KEY_RANGE-1.
  function automatic int bucket_span(input int key_buckets);
    return (key_buckets < KEY_RANGE) ? key_buckets : KEY_RANGE;
  endfunction

  // Bits of a bucket index.
  function automatic int bucket_bits(input int key_buckets);
    return $clog2(bucket_span(key_buckets));
  endfunction

  // Width of one queued operation: sort flag, tag and clamped key.
  function automatic int op_width(input int key_buckets, input int tag_bits);
    return 1 + tag_bits + bucket_bits(key_buckets);
  endfunction

endpackage

[src/csd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: channel interfaces
// Valid/ready channels for input transactions, result transactions and the
// internal operation queue.
// ----------------------------------------------------------------------------

// Input channel: a load or a sort command.
interface csd_in_if import csd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [TAG_W-1:0] item_tag;
  logic [KEY_W-1:0] sort_key;

  modport source (output valid, cmd, item_tag, sort_key, input ready);
  modport sink   (input valid, cmd, item_tag, sort_key, output ready);
endinterface

// Result channel: one sorted tag per transaction.
interface csd_out_if import csd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] sorted_tag;
  logic             last;
  logic             overflow;

  modport source (output valid, sorted_tag, last, overflow, input ready);
  modport sink   (input valid, sorted_tag, last, overflow, output ready);
endinterface

// Internal operation channel between front end, queue and sort engine.
interface csd_op_if #(parameter int W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[src/counting_sort_by_distance_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: top level
// Stable counting sort of tagged items by an 8-bit distance key.
// ----------------------------------------------------------------------------
// A load transaction (cmd = 0) stores one tag and key; loads are taken one per
// cycle while the engine is idle, and a short queue absorbs a few more while
// it is busy. Loads past MAX_ITEMS are dropped and reported through overflow
// on the results of the next sort. A sort transaction (cmd = 1) occupies the
// sort engine, before its first result, with a histogram pass and a scatter
// pass over the n stored items, each item being a read-modify-write of the
// bucket memory, a prefix-sum pass over the B = min(KEY_BUCKETS, 256) buckets,
// and one set-up step before each of the prefix and emit passes.
// The n results then leave one per cycle while the result side is ready, last
// marking the final one. A sort with no stored items produces no results and
// only clears the overflow flag.
// ----------------------------------------------------------------------------
module counting_sort_by_distance_unit import csd_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int KEY_BUCKETS = KEY_BUCKETS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  csd_in_if.sink    items,
  csd_out_if.source results
);

  localparam int OW = op_width(KEY_BUCKETS, TAG_BITS);

  csd_op_if #(.W(OW)) front_ops ();
  csd_op_if #(.W(OW)) queued_ops ();

  // Decode and register incoming transactions.
  csd_front #(
    .KEY_BUCKETS (KEY_BUCKETS),
    .TAG_BITS    (TAG_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .ops   (front_ops)
  );

  // Decouple the front end from the sort engine.
  csd_queue #(
    .W     (OW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_ops),
    .rd  (queued_ops)
  );

  // Store, sort and emit.
  csd_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .KEY_BUCKETS (KEY_BUCKETS),
    .TAG_BITS    (TAG_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .ops     (queued_ops),
    .results (results)
  );

endmodule

[src/csd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: front end
// Accepts input transactions, decodes the command, clamps the key into the
// bucket range, trims the tag and registers the resulting operation.
// ----------------------------------------------------------------------------
module csd_front import csd_pkg::*; #(
  parameter int KEY_BUCKETS = KEY_BUCKETS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  csd_in_if.sink  items,
  csd_op_if.source ops
);

  localparam int BW = bucket_bits(KEY_BUCKETS);
  localparam int OW = op_width(KEY_BUCKETS, TAG_BITS);

  logic          op_valid;
  logic [OW-1:0] op_data;
  logic [BW-1:0] key_c;
  logic          is_sort;

  // Keys beyond the top bucket saturate into it.
  always_comb begin
    if (int'(items.sort_key) >= KEY_BUCKETS) begin
      key_c = BW'(KEY_BUCKETS - 1);
    end else begin
      key_c = BW'(items.sort_key);
    end
    is_sort = (items.cmd == CMD_SORT);
  end

  // The stage takes a new transaction whenever it is empty or being drained.
  assign items.ready = !op_valid || ops.ready;
  assign ops.valid   = op_valid;
  assign ops.data    = op_data;

  // Operation register.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      if (items.valid && items.ready) begin
        op_valid <= 1'b1;
        op_data  <= {is_sort, TAG_BITS'(items.item_tag), key_c};
      end else if (ops.ready) begin
        op_valid <= 1'b0;
      end
    end
  end

endmodule

[src/csd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: operation queue
// Small register FIFO that lets the front end keep accepting loads while the
// sort engine is busy, and lets either side stall on its own.
// ----------------------------------------------------------------------------
module csd_queue import csd_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  csd_op_if.sink   wr,
  csd_op_if.source rd
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          push;
  logic          pop;

  assign wr.ready = (fill != (PW + 1)'(DEPTH));
  assign rd.valid = (fill != '0);
  assign rd.data  = entries[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  // Storage; pointers wrap naturally as the depth is a power of two.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr.data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW + 1)'(1);
      end
    end
  end

endmodule

[src/csd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: sort engine
// Stores loaded items, and on a sort command runs the histogram, prefix sum,
// scatter and emit passes over its item, bucket and output memories.
// ----------------------------------------------------------------------------
module csd_back import csd_pkg::*; #(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int KEY_BUCKETS = KEY_BUCKETS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  csd_op_if.sink    ops,
  csd_out_if.source results
);

  localparam int NB = bucket_span(KEY_BUCKETS);
  localparam int BW = bucket_bits(KEY_BUCKETS);
  localparam int OW = op_width(KEY_BUCKETS, TAG_BITS);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int MW = TAG_BITS + BW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HKEY,
    S_HUPD,
    S_PPRE,
    S_PRUN,
    S_SKEY,
    S_SUPD,
    S_EPRE,
    S_EMIT
  } state_t;

  state_t state;

  // Memories: loaded items, bucket counts/offsets and sorted tags.
  logic [MW-1:0]    itm_mem [MAX_ITEMS];
  logic [CW-1:0]    cnt_mem [NB];
  logic [TAG_W-1:0] out_mem [MAX_ITEMS];
  logic [MW-1:0]    itm_q;
  logic [CW-1:0]    cnt_q;
  logic [TAG_W-1:0] out_q;

  // Control and payload registers.
  logic [CW-1:0]       count;
  logic                dropped;
  logic [CW-1:0]       n;
  logic                ovf;
  logic [CW-1:0]       i;
  logic [BW-1:0]       b;
  logic [CW-1:0]       running;
  logic [BW-1:0]       key_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [NB-1:0]       bkt_vld;
  logic                res_valid;
  logic [TAG_W-1:0]    res_tag;
  logic                res_last;
  logic                res_ovf;

  // Decoded fields and memory controls.
  logic                op_sort;
  logic [TAG_BITS-1:0] op_tag;
  logic [BW-1:0]       op_key;
  logic [BW-1:0]       itm_key;
  logic [TAG_BITS-1:0] itm_tag;
  logic [IW-1:0]       itm_raddr;
  logic [BW-1:0]       cnt_raddr;
  logic [IW-1:0]       out_raddr;
  logic                itm_we;
  logic                cnt_we;
  logic [BW-1:0]       cnt_waddr;
  logic [CW-1:0]       cnt_wdata;
  logic                out_we;
  logic [CW-1:0]       cval;
  logic [CW-1:0]       hcnt;
  logic [CW-1:0]       i_inc;
  logic                i_last;
  logic                b_last;
  logic                can_load;

  assign op_sort = ops.data[OW-1];
  assign op_tag  = ops.data[OW-2 -: TAG_BITS];
  assign op_key  = ops.data[BW-1:0];
  assign itm_key = itm_q[BW-1:0];
  assign itm_tag = itm_q[BW +: TAG_BITS];

  assign ops.ready          = (state == S_IDLE);
  assign results.valid      = res_valid;
  assign results.sorted_tag = res_tag;
  assign results.last       = res_last;
  assign results.overflow   = res_ovf;

  assign i_inc    = i + CW'(1);
  assign i_last   = (i == n - CW'(1));
  assign b_last   = (b == BW'(NB - 1));
  assign can_load = !res_valid || results.ready;

  // Memory addressing for each pass. Reads are registered, so an address
  // chosen here gives its data in the following cycle.
  always_comb begin
    itm_raddr = '0;
    cnt_raddr = '0;
    out_raddr = '0;
    itm_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    out_we    = 1'b0;
    cval      = bkt_vld[b] ? cnt_q : '0;
    hcnt      = bkt_vld[key_r] ? cnt_q : '0;
    unique case (state)
      S_IDLE: begin
        itm_we = ops.valid && !op_sort && (count < CW'(MAX_ITEMS));
      end
      S_HKEY: begin
        itm_raddr = i[IW-1:0];
        cnt_raddr = itm_key;
      end
      S_HUPD: begin
        cnt_we    = 1'b1;
        cnt_waddr = key_r;
        cnt_wdata = hcnt + CW'(1);
        if (!i_last) begin
          itm_raddr = i_inc[IW-1:0];
        end
      end
      S_PRUN: begin
        cnt_we    = 1'b1;
        cnt_waddr = b;
        cnt_wdata = running;
        cnt_raddr = b_last ? b : b + BW'(1);
      end
      S_SKEY: begin
        itm_raddr = i[IW-1:0];
        cnt_raddr = itm_key;
      end
      S_SUPD: begin
        out_we    = 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = key_r;
        cnt_wdata = cnt_q + CW'(1);
        if (!i_last) begin
          itm_raddr = i_inc[IW-1:0];
        end
      end
      S_EMIT: begin
        out_raddr = (can_load && !i_last) ? i_inc[IW-1:0] : i[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Item memory: written on load, read by the histogram and scatter passes.
  always_ff @(posedge clk) begin
    if (itm_we) begin
      itm_mem[count[IW-1:0]] <= {op_tag, op_key};
    end
    itm_q <= itm_mem[itm_raddr];
  end

  // Bucket memory: counts, then running offsets.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  // Output memory: scattered tags, read back in order on emit.
  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[cnt_q[IW-1:0]] <= TAG_W'(tag_r);
    end
    out_q <= out_mem[out_raddr];
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
      bkt_vld   <= '0;
    end else begin
      // Outside the emit pass an accepted result simply leaves the register.
      if (results.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ops.valid) begin
            if (op_sort) begin
              n       <= count;
              ovf     <= dropped;
              count   <= '0;
              dropped <= 1'b0;
              if (count != '0) begin
                bkt_vld <= '0;
                i       <= '0;
                state   <= S_HKEY;
              end
            end else if (count < CW'(MAX_ITEMS)) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_HKEY: begin
          key_r <= itm_key;
          state <= S_HUPD;
        end
        S_HUPD: begin
          bkt_vld[key_r] <= 1'b1;
          if (i_last) begin
            state <= S_PPRE;
          end else begin
            i     <= i_inc;
            state <= S_HKEY;
          end
        end
        S_PPRE: begin
          b       <= '0;
          running <= '0;
          state   <= S_PRUN;
        end
        S_PRUN: begin
          bkt_vld[b] <= 1'b1;
          running    <= running + cval;
          if (b_last) begin
            i     <= '0;
            state <= S_SKEY;
          end else begin
            b <= b + BW'(1);
          end
        end
        S_SKEY: begin
          key_r <= itm_key;
          tag_r <= itm_tag;
          state <= S_SUPD;
        end
        S_SUPD: begin
          if (i_last) begin
            i     <= '0;
            state <= S_EPRE;
          end else begin
            i     <= i_inc;
            state <= S_SKEY;
          end
        end
        S_EPRE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          res_valid <= !can_load;
          if (can_load) begin
            res_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Result payload and emit progress.
      if ((state == S_EMIT) && can_load) begin
        res_tag  <= out_q;
        res_last <= i_last;
        res_ovf  <= ovf;
        if (i_last) begin
          state <= S_IDLE;
        end else begin
          i <= i_inc;
        end
      end
    end
  end

endmodule

[src/csd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: port checker
// Watches the result channel of the top level for reset behaviour, stall
// behaviour and the consistency of each burst of sorted results.
// ----------------------------------------------------------------------------
module csd_checker import csd_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic [TAG_W-1:0] res_tag,
  input logic             res_last,
  input logic             res_ovf
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic          res_acc;
  logic          in_burst;
  logic          burst_ovf;
  logic [CW-1:0] burst_cnt;

  assign res_acc = res_valid && res_ready;

  // Track the burst of results that belongs to one sort.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_burst  <= 1'b0;
      burst_ovf <= 1'b0;
      burst_cnt <= '0;
    end else if (res_acc) begin
      if (res_last) begin
        in_burst  <= 1'b0;
        burst_cnt <= '0;
      end else begin
        in_burst  <= 1'b1;
        burst_ovf <= res_ovf;
        burst_cnt <= burst_cnt + CW'(1);
      end
    end
  end

  // No result is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(res_tag) && $stable(res_last) && $stable(res_ovf))
    else $error("stalled result changed");

  // All results of one sort report the same overflow status.
  a_burst_ovf: assert property (@(posedge clk) disable iff (rst)
    res_acc && in_burst |-> res_ovf == burst_ovf)
    else $error("overflow changed within a sort");

  // A sort never produces more results than the store can hold.
  a_burst_len: assert property (@(posedge clk) disable iff (rst)
    res_acc && (burst_cnt == CW'(MAX_ITEMS - 1)) |-> res_last)
    else $error("sort produced too many results");

endmodule

bind counting_sort_by_distance_unit csd_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_csd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_tag   (results.sorted_tag),
  .res_last  (results.last),
  .res_ovf   (results.overflow)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting sort by distance: block-level testbench
// Loads tagged items and issues sort commands through the input channel. A
// software copy of the sort predicts every result transaction. Each result is
// checked in order against that prediction, tag, last marker and overflow
// flag. Both channels pause at random, and one test holds the result side
// off long enough for the block to back up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import csd_pkg::*;

  // Block configuration used for this run.
  localparam int SET_CAPACITY  = MAX_ITEMS_DEF;
  localparam int BUCKET_COUNT  = KEY_BUCKETS_DEF;
  localparam int TAG_BITS_USED = TAG_BITS_DEF;

  // Run control.
  localparam int ITEM_TARGET    = 360;
  localparam int CALM_FROM      = 300;
  localparam int HOLD_OFF_LEN   = 900;
  localparam int SETTLE_CYCLES  = 600;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected result transaction.
  typedef struct packed {
    logic [TAG_W-1:0] sorted_tag;
    logic             last;
    logic             overflow;
  } sorted_entry_t;

  logic clk;
  logic rst;

  csd_in_if  items_ch ();
  csd_out_if results_ch ();

  counting_sort_by_distance_unit #(
    .MAX_ITEMS   (SET_CAPACITY),
    .KEY_BUCKETS (BUCKET_COUNT),
    .TAG_BITS    (TAG_BITS_USED)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // Predicted state of the item set.
  logic [TAG_W-1:0] held_tags [SET_CAPACITY];
  logic [KEY_W-1:0] held_keys [SET_CAPACITY];
  int               held_count;
  bit               loads_dropped;
  sorted_entry_t    pending_sorted[$];

  int failures;
  int items_sent;
  bit idle_on;
  int hold_off_req;
  int quiet_cycles;

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Applies one accepted transaction to the predicted set; a sort queues the
  // tags in ascending key order, keeping arrival order among equal keys.
  function automatic void predict_sort(cmd_t op, logic [TAG_W-1:0] tag,
                                       logic [KEY_W-1:0] key);
    sorted_entry_t entry;
    int            emitted;
    int            bucket;
    if (op == CMD_LOAD) begin
      if (held_count < SET_CAPACITY) begin
        bucket = (int'(key) >= BUCKET_COUNT) ? BUCKET_COUNT - 1 : int'(key);
        held_tags[held_count] = tag & TAG_W'((64'd1 << TAG_BITS_USED) - 1);
        held_keys[held_count] = KEY_W'(bucket);
        held_count++;
      end else begin
        loads_dropped = 1'b1;
      end
    end else begin
      emitted = 0;
      for (int b = 0; b < BUCKET_COUNT; b++) begin
        for (int i = 0; i < held_count; i++) begin
          if (int'(held_keys[i]) == b) begin
            entry.sorted_tag = held_tags[i];
            entry.last       = (emitted == held_count - 1);
            entry.overflow   = loads_dropped;
            pending_sorted   = {pending_sorted, entry};
            emitted++;
          end
        end
      end
      held_count    = 0;
      loads_dropped = 1'b0;
    end
  endfunction

  // Compares one result transaction with the oldest prediction.
  function automatic void check_sorted(logic [TAG_W-1:0] tag, logic lst, logic ovf);
    sorted_entry_t want;
    if (pending_sorted.size() == 0) begin
      $error("unexpected result: sorted_tag %h last %b overflow %b", tag, lst, ovf);
      failures++;
      return;
    end
    want = pending_sorted.pop_front();
    if (tag !== want.sorted_tag) begin
      $error("sorted_tag: expected %h, actual %h", want.sorted_tag, tag);
      failures++;
    end
    if (lst !== want.last) begin
      $error("last: expected %b, actual %b", want.last, lst);
      failures++;
    end
    if (ovf !== want.overflow) begin
      $error("overflow: expected %b, actual %b", want.overflow, ovf);
      failures++;
    end
  endfunction

  // Observes both channels at each edge and feeds the predictor and checker.
  always @(posedge clk) begin
    if (!rst && items_ch.valid === 1'b1 && items_ch.ready === 1'b1)
      predict_sort(cmd_t'(items_ch.cmd), items_ch.item_tag, items_ch.sort_key);
    if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
      check_sorted(results_ch.sorted_tag, results_ch.last, results_ch.overflow);
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (items_ch.valid === 1'b1 && items_ch.ready === 1'b1) ||
        (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, ready stretches, and a long hold-off
  // when a test asks for one.
  always begin : result_sink
    int span;
    @(posedge clk);
    if (!rst && hold_off_req != 0) begin
      span         = hold_off_req;
      hold_off_req = 0;
      results_ch.ready <= 1'b0;
      repeat (span - 1) @(posedge clk);
    end else if (!rst && idle_on && $urandom_range(0, 3) == 0) begin
      results_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(posedge clk);
    end else begin
      results_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk);
    end
  end

  // Offers one transaction, after an optional idle burst, and waits until it
  // is accepted. Valid is left high for the next transaction.
  task automatic send_item(cmd_t op, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    items_ch.valid    <= 1'b1;
    items_ch.cmd      <= op;
    items_ch.item_tag <= tag;
    items_ch.sort_key <= key;
    do @(posedge clk); while (items_ch.ready !== 1'b1);
    items_sent++;
  endtask

  // Sorts with an empty set, a set spanning the field extremes with equal
  // keys, and a single item.
  task automatic test_directed_orders();
    send_item(CMD_SORT, 16'h0000, 8'h00);
    send_item(CMD_LOAD, 16'hFFFF, 8'hFF);
    send_item(CMD_LOAD, 16'h0000, 8'h00);
    send_item(CMD_LOAD, 16'h1234, 8'hFF);
    send_item(CMD_LOAD, 16'hAAAA, 8'h00);
    send_item(CMD_LOAD, 16'h5555, 8'h80);
    send_item(CMD_LOAD, 16'h8001, 8'h01);
    send_item(CMD_SORT, 16'hFFFF, 8'hFF);
    send_item(CMD_LOAD, 16'h7E57, 8'h7F);
    send_item(CMD_SORT, 16'h0000, 8'h00);
    send_item(CMD_SORT, 16'h0000, 8'h00);
  endtask

  // Fills the set, drops a few loads, then checks that the flag is cleared
  // for the following sort.
  task automatic test_full_set_drops();
    for (int i = 0; i < SET_CAPACITY + 3; i++)
      send_item(CMD_LOAD, 16'($urandom), 8'($urandom_range(0, 255)));
    send_item(CMD_SORT, 16'($urandom), 8'($urandom));
    send_item(CMD_LOAD, 16'h0F0F, 8'h10);
    send_item(CMD_LOAD, 16'hF0F0, 8'h08);
    send_item(CMD_SORT, 16'($urandom), 8'($urandom));
  endtask

  // Holds the result side off while loads keep coming, so that the block
  // backs up and stalls its input.
  task automatic test_result_backpressure();
    idle_on      = 1'b0;
    hold_off_req = HOLD_OFF_LEN;
    for (int i = 0; i < 20; i++)
      send_item(CMD_LOAD, 16'($urandom), 8'($urandom_range(0, 7)));
    send_item(CMD_SORT, 16'($urandom), 8'($urandom));
    for (int i = 0; i < 12; i++)
      send_item(CMD_LOAD, 16'($urandom), 8'($urandom));
    send_item(CMD_SORT, 16'($urandom), 8'($urandom));
    idle_on = 1'b1;
  endtask

  // Random sets of loads, each closed by a sort: mostly small sets, some
  // empty ones and some that overrun the capacity.
  task automatic test_random_sets();
    int pick;
    int set_size;
    int key_mode;
    logic [KEY_W-1:0] key;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM)
        idle_on = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick == 0)
        set_size = 0;
      else if (pick == 1)
        set_size = $urandom_range(SET_CAPACITY - 2, SET_CAPACITY + 4);
      else
        set_size = $urandom_range(1, 12);
      key_mode = $urandom_range(0, 2);
      for (int i = 0; i < set_size; i++) begin
        case (key_mode)
          0: key = 8'($urandom_range(0, 255));
          1: key = 8'($urandom_range(0, 3));
          default: key = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        endcase
        send_item(CMD_LOAD, 16'($urandom), key);
      end
      send_item(CMD_SORT, 16'($urandom), 8'($urandom));
    end
  endtask

  // Main sequence: reset, tests in turn, drain and verdict.
  initial begin
    failures          = 0;
    items_sent        = 0;
    held_count        = 0;
    loads_dropped     = 1'b0;
    idle_on           = 1'b1;
    hold_off_req      = 0;
    quiet_cycles      = 0;
    rst               = 1'b1;
    items_ch.valid    <= 1'b0;
    items_ch.cmd      <= CMD_LOAD;
    items_ch.item_tag <= '0;
    items_ch.sort_key <= '0;
    results_ch.ready  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_orders();
    test_full_set_drops();
    test_result_backpressure();
    test_random_sets();
    items_ch.valid <= 1'b0;

    // Wait for every predicted result, then let the block settle.
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_sorted.size() != 0) begin
      $error("%0d expected results never arrived", pending_sorted.size());
      failures++;
    end
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[counting_sort_by_distance_unit.f]
src/csd_pkg.sv
src/csd_if.sv
src/csd_front.sv
src/csd_queue.sv
src/csd_back.sv
src/counting_sort_by_distance_unit.sv
src/csd_checker.sv
dv/testbench.sv
